// ----- rtl/core/obstacle_line_parser_core_assert.svh -----
// ---------------------------------------------------------------------------
// obstacle line parser assertion macros
// shared concurrent check forms, clocked on clk with synchronous reset rst
// ---------------------------------------------------------------------------
`ifndef OBSTACLE_LINE_PARSER_CORE_ASSERT_SVH
`define OBSTACLE_LINE_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define OLP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OLP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/olp_pkg.sv -----
// ---------------------------------------------------------------------------
// obstacle line parser package
// parse phases, character codes, color codes and literal lookups
// ---------------------------------------------------------------------------
package olp_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int LEN_W         = $clog2(LINE_CAPACITY);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);

  typedef enum logic [2:0] {
    PH_PREFIX    = 3'd0,
    PH_NAME      = 3'd1,
    PH_N1_START  = 3'd2,
    PH_N1_DIGITS = 3'd3,
    PH_N2_START  = 3'd4,
    PH_N2_DIGITS = 3'd5,
    PH_DONE      = 3'd6,
    PH_FAIL      = 3'd7
  } phase_t;

  localparam logic [1:0] COLOR_NONE  = 2'd0;
  localparam logic [1:0] COLOR_RED   = 2'd1;
  localparam logic [1:0] COLOR_GREEN = 2'd2;

  localparam logic [1:0] CAND_RED   = 2'b01;
  localparam logic [1:0] CAND_GREEN = 2'b10;
  localparam logic [1:0] CAND_BOTH  = 2'b11;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] NONE_LEN   = 4'd9;
  localparam logic [3:0] PREFIX_LEN = 4'd5;
  localparam logic [2:0] RED_LEN    = 3'd3;
  localparam logic [2:0] GREEN_LEN  = 3'd5;
  localparam logic [2:0] NAME_MAX   = 3'd7;

  // "OBST:NONE"
  function automatic logic [7:0] none_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h4f;
      4'd1:    ch = 8'h42;
      4'd2:    ch = 8'h53;
      4'd3:    ch = 8'h54;
      4'd4:    ch = 8'h3a;
      4'd5:    ch = 8'h4e;
      4'd6:    ch = 8'h4f;
      4'd7:    ch = 8'h4e;
      4'd8:    ch = 8'h45;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "RED"
  function automatic logic [7:0] red_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h52;
      2'd1:    ch = 8'h45;
      2'd2:    ch = 8'h44;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "GREEN"
  function automatic logic [7:0] green_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h47;
      3'd1:    ch = 8'h52;
      3'd2:    ch = 8'h45;
      3'd3:    ch = 8'h45;
      3'd4:    ch = 8'h4e;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // space, tab, vertical tab, form feed (line end and return never get here)
  function automatic logic is_blank(input logic [7:0] ch);
    return (ch == 8'd32) || (ch == 8'd9) || (ch == 8'd11) || (ch == 8'd12);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

endpackage

// ----- rtl/core/obstacle_line_parser_core.sv -----
// ---------------------------------------------------------------------------
// obstacle line parser core
// streaming parser for newline-terminated obstacle report lines
// ---------------------------------------------------------------------------
// One received byte is taken per beat and folded into a small parse state, so
// the core sustains one byte per clock. A good line (OBST:NONE..., or
// OBST:RED / OBST:GREEN followed by two signed decimals) yields one result
// beat in the cycle after its newline byte is accepted, from an output
// register. The input is held off only when a newline arrives while an
// earlier result still sits unclaimed in that register; all other bytes
// pass freely. Carriage returns are dropped, a NUL hides the rest of the
// line, and a line reaching olp_pkg::LINE_CAPACITY characters restarts.
// There is no line buffer and no clearing pass after reset.
`include "obstacle_line_parser_core_assert.svh"

module obstacle_line_parser_core (
  input  logic        clk,
  input  logic        rst,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  obstacle_color,
  output logic signed [15:0] fwd_offset,
  output logic signed [15:0] side_offset
);

  // parse state registers
  olp_pkg::phase_t                 parse_phase, parse_phase_next;
  logic [olp_pkg::LEN_W-1:0]       line_length, line_length_next;
  logic [3:0]                      literal_index, literal_index_next;
  logic                            none_prefix_seen, none_prefix_seen_next;
  logic [2:0]                      name_length, name_length_next;
  logic [1:0]                      name_candidates, name_candidates_next;
  logic [15:0]                     number_accumulator, number_accumulator_next;
  logic                            number_negative, number_negative_next;
  logic                            digit_seen, digit_seen_next;
  logic [15:0]                     first_value, first_value_next;
  logic                            text_ended, text_ended_next;

  // result formed this cycle
  logic        result_hit;
  logic [1:0]  result_color;
  logic [15:0] result_distance;
  logic [15:0] result_lateral;

  logic        in_beat;
  logic [15:0] number_value;
  logic [15:0] digit_value;
  logic [15:0] acc_times_ten;
  olp_pkg::phase_t digits_phase;

  // a newline may create a result, so it waits while the result register is held
  assign in_stall = out_valid && out_stall && (rx_byte == olp_pkg::CH_LF);
  assign in_beat  = in_valid && !in_stall;

  assign number_value  = number_negative ? (16'd0 - number_accumulator) : number_accumulator;
  assign digit_value   = {8'd0, rx_byte - olp_pkg::CH_ZERO};
  assign acc_times_ten = (number_accumulator << 3) + (number_accumulator << 1);
  assign digits_phase  = (parse_phase == olp_pkg::PH_N1_START) ?
                         olp_pkg::PH_N1_DIGITS : olp_pkg::PH_N2_DIGITS;

  always_comb begin
    parse_phase_next        = parse_phase;
    line_length_next        = line_length;
    literal_index_next      = literal_index;
    none_prefix_seen_next   = none_prefix_seen;
    name_length_next        = name_length;
    name_candidates_next    = name_candidates;
    number_accumulator_next = number_accumulator;
    number_negative_next    = number_negative;
    digit_seen_next         = digit_seen;
    first_value_next        = first_value;
    text_ended_next         = text_ended;
    result_hit              = 1'b0;
    result_color            = olp_pkg::COLOR_NONE;
    result_distance         = 16'd0;
    result_lateral          = 16'd0;

    if (rx_byte == olp_pkg::CH_LF) begin
      // end of line: report if good, then restart
      if (none_prefix_seen) begin
        result_hit = 1'b1;
      end else if ((parse_phase == olp_pkg::PH_DONE) ||
                   ((parse_phase == olp_pkg::PH_N2_DIGITS) && digit_seen)) begin
        result_hit      = 1'b1;
        result_color    = (name_candidates == olp_pkg::CAND_GREEN) ?
                          olp_pkg::COLOR_GREEN : olp_pkg::COLOR_RED;
        result_distance = first_value;
        result_lateral  = number_value;
      end
    end else if (rx_byte == olp_pkg::CH_CR) begin
      // dropped, not counted
    end else if (line_length >= olp_pkg::LEN_MAX) begin
      // overlong line, restart below
    end else begin
      line_length_next = line_length + 1'b1;
      if (rx_byte == olp_pkg::CH_NUL) begin
        text_ended_next = 1'b1;
      end else if (!text_ended) begin
        // track the no-obstacle literal independently of the main parse
        if ((olp_pkg::LEN_W'(literal_index) == line_length) &&
            (line_length < olp_pkg::LEN_W'(olp_pkg::NONE_LEN)) &&
            (rx_byte == olp_pkg::none_char(line_length[3:0]))) begin
          literal_index_next = literal_index + 1'b1;
          if (literal_index == olp_pkg::NONE_LEN - 4'd1) begin
            none_prefix_seen_next = 1'b1;
          end
        end

        unique case (parse_phase)
          olp_pkg::PH_PREFIX: begin
            if ((line_length < olp_pkg::LEN_W'(olp_pkg::PREFIX_LEN)) &&
                (rx_byte == olp_pkg::none_char(line_length[3:0]))) begin
              if (line_length == olp_pkg::LEN_W'(olp_pkg::PREFIX_LEN - 4'd1)) begin
                parse_phase_next = olp_pkg::PH_NAME;
              end
            end else begin
              parse_phase_next = olp_pkg::PH_FAIL;
            end
          end
          olp_pkg::PH_NAME: begin
            if (rx_byte == olp_pkg::CH_COMMA) begin
              if ((name_length == olp_pkg::RED_LEN) && name_candidates[0]) begin
                name_candidates_next = olp_pkg::CAND_RED;
                parse_phase_next     = olp_pkg::PH_N1_START;
              end else if ((name_length == olp_pkg::GREEN_LEN) && name_candidates[1]) begin
                name_candidates_next = olp_pkg::CAND_GREEN;
                parse_phase_next     = olp_pkg::PH_N1_START;
              end else begin
                name_candidates_next = 2'b00;
                parse_phase_next     = olp_pkg::PH_FAIL;
              end
            end else if (name_length == olp_pkg::NAME_MAX) begin
              parse_phase_next = olp_pkg::PH_FAIL;
            end else begin
              if (!((name_length < olp_pkg::RED_LEN) &&
                    (rx_byte == olp_pkg::red_char(name_length[1:0])))) begin
                name_candidates_next[0] = 1'b0;
              end
              if (!((name_length < olp_pkg::GREEN_LEN) &&
                    (rx_byte == olp_pkg::green_char(name_length)))) begin
                name_candidates_next[1] = 1'b0;
              end
              name_length_next = name_length + 1'b1;
            end
          end
          olp_pkg::PH_N1_START, olp_pkg::PH_N2_START: begin
            if (!olp_pkg::is_blank(rx_byte)) begin
              number_accumulator_next = 16'd0;
              number_negative_next    = 1'b0;
              digit_seen_next         = 1'b0;
              if ((rx_byte == olp_pkg::CH_PLUS) || (rx_byte == olp_pkg::CH_MINUS)) begin
                number_negative_next = (rx_byte == olp_pkg::CH_MINUS);
                parse_phase_next     = digits_phase;
              end else if (olp_pkg::is_digit(rx_byte)) begin
                number_accumulator_next = digit_value;
                digit_seen_next         = 1'b1;
                parse_phase_next        = digits_phase;
              end else begin
                parse_phase_next = olp_pkg::PH_FAIL;
              end
            end
          end
          olp_pkg::PH_N1_DIGITS: begin
            if (olp_pkg::is_digit(rx_byte)) begin
              number_accumulator_next = acc_times_ten + digit_value;
              digit_seen_next         = 1'b1;
            end else if ((rx_byte == olp_pkg::CH_COMMA) && digit_seen) begin
              first_value_next = number_value;
              parse_phase_next = olp_pkg::PH_N2_START;
            end else begin
              parse_phase_next = olp_pkg::PH_FAIL;
            end
          end
          olp_pkg::PH_N2_DIGITS: begin
            if (olp_pkg::is_digit(rx_byte)) begin
              number_accumulator_next = acc_times_ten + digit_value;
              digit_seen_next         = 1'b1;
            end else begin
              parse_phase_next = digit_seen ? olp_pkg::PH_DONE : olp_pkg::PH_FAIL;
            end
          end
          olp_pkg::PH_DONE, olp_pkg::PH_FAIL: begin
            // trailing text ignored
          end
        endcase
      end
    end

    // newline or overlong line: back to the start of a line
    if ((rx_byte == olp_pkg::CH_LF) ||
        ((rx_byte != olp_pkg::CH_CR) && (line_length >= olp_pkg::LEN_MAX))) begin
      parse_phase_next        = olp_pkg::PH_PREFIX;
      line_length_next        = '0;
      literal_index_next      = 4'd0;
      none_prefix_seen_next   = 1'b0;
      name_length_next        = 3'd0;
      name_candidates_next    = olp_pkg::CAND_BOTH;
      number_accumulator_next = 16'd0;
      number_negative_next    = 1'b0;
      digit_seen_next         = 1'b0;
      first_value_next        = 16'd0;
      text_ended_next         = 1'b0;
    end
  end

  // parse state, updated on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase        <= olp_pkg::PH_PREFIX;
      line_length        <= '0;
      literal_index      <= 4'd0;
      none_prefix_seen   <= 1'b0;
      name_length        <= 3'd0;
      name_candidates    <= olp_pkg::CAND_BOTH;
      number_accumulator <= 16'd0;
      number_negative    <= 1'b0;
      digit_seen         <= 1'b0;
      first_value        <= 16'd0;
      text_ended         <= 1'b0;
    end else if (in_beat) begin
      parse_phase        <= parse_phase_next;
      line_length        <= line_length_next;
      literal_index      <= literal_index_next;
      none_prefix_seen   <= none_prefix_seen_next;
      name_length        <= name_length_next;
      name_candidates    <= name_candidates_next;
      number_accumulator <= number_accumulator_next;
      number_negative    <= number_negative_next;
      digit_seen         <= digit_seen_next;
      first_value        <= first_value_next;
      text_ended         <= text_ended_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat && result_hit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && result_hit) begin
      obstacle_color <= result_color;
      fwd_offset     <= result_distance;
      side_offset    <= result_lateral;
    end
  end

  `OLP_ASSERT_IMP(a_len_bound, 1'b1, line_length <= olp_pkg::LEN_MAX,
                  "line length beyond capacity")
  `OLP_ASSERT_NXT(a_newline_restart, in_beat && (rx_byte == olp_pkg::CH_LF),
                  (parse_phase == olp_pkg::PH_PREFIX) && (line_length == '0),
                  "newline did not restart the line")
  `OLP_ASSERT_IMP(a_none_zero, out_valid && (obstacle_color == olp_pkg::COLOR_NONE),
                  (fwd_offset == 16'sd0) && (side_offset == 16'sd0),
                  "no-obstacle result with nonzero offsets")
  `OLP_ASSERT_IMP(a_literal_bound, 1'b1,
                  (olp_pkg::LEN_W'(literal_index) <= line_length) &&
                  (literal_index <= olp_pkg::NONE_LEN),
                  "literal index ahead of line position")

endmodule
